FILE: design/lrukf_pkg.sv
// Shared constants, codes and types for the LRU-K frame replacer.
// No dependencies; imported by lrukf_victim_sel, lru_k_frame_replacer and the testbench.
package lrukf_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int MAX_K      = 4;
    localparam int SLOT_W     = $clog2(MAX_K);
    localparam int FILL_W     = $clog2(MAX_K + 1);
    localparam int STAMP_W    = 32;
    localparam int ADDR_W     = FRAME_W + SLOT_W;
    localparam int COUNT_W    = 7;
    localparam int LIMIT_W    = 7;
    localparam int DEPTH_W    = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCESS = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_VICTIM = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_DEPTH = 1'b1;

    typedef struct packed {
        logic               short_found;
        logic [FRAME_W-1:0] short_frame;
        logic               full_found;
        logic [FRAME_W-1:0] full_frame;
    } sel_result_t;

endpackage

FILE: design/lrukf_victim_sel.sv
// Victim selection: keeps the best candidate of each class with one comparator.
// Depends on lrukf_pkg.
module lrukf_victim_sel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  logic                               valid,
    input  logic [lrukf_pkg::FRAME_W-1:0]      cand_frame,
    input  logic                               cand_full,
    input  logic [lrukf_pkg::STAMP_W-1:0]      cand_key,
    output lrukf_pkg::sel_result_t             result
);
    import lrukf_pkg::*;

    logic               short_found_reg, short_found_next;
    logic               full_found_reg, full_found_next;
    logic [FRAME_W-1:0] short_frame_reg, short_frame_next;
    logic [FRAME_W-1:0] full_frame_reg, full_frame_next;
    logic [STAMP_W-1:0] short_key_reg, short_key_next;
    logic [STAMP_W-1:0] full_key_reg, full_key_next;
    logic               cur_found;
    logic [STAMP_W-1:0] cur_key;
    logic               take;

    always_comb
    begin
        cur_found = cand_full ? full_found_reg : short_found_reg;
        cur_key   = cand_full ? full_key_reg : short_key_reg;
        take      = valid && (!cur_found || (cand_key < cur_key));

        short_found_next = short_found_reg;
        short_frame_next = short_frame_reg;
        short_key_next   = short_key_reg;
        full_found_next  = full_found_reg;
        full_frame_next  = full_frame_reg;
        full_key_next    = full_key_reg;
        if (clear)
        begin
            short_found_next = 1'b0;
            full_found_next  = 1'b0;
        end
        else if (take)
        begin
            if (cand_full)
            begin
                full_found_next = 1'b1;
                full_frame_next = cand_frame;
                full_key_next   = cand_key;
            end
            else
            begin
                short_found_next = 1'b1;
                short_frame_next = cand_frame;
                short_key_next   = cand_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_found_reg <= 1'b0;
            full_found_reg  <= 1'b0;
        end
        else
        begin
            short_found_reg <= short_found_next;
            full_found_reg  <= full_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        short_frame_reg <= short_frame_next;
        short_key_reg   <= short_key_next;
        full_frame_reg  <= full_frame_next;
        full_key_reg    <= full_key_next;
    end

    assign result.short_found = short_found_reg;
    assign result.short_frame = short_frame_reg;
    assign result.full_found  = full_found_reg;
    assign result.full_frame  = full_frame_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> !short_found_reg && !full_found_reg)
        else $error("selector not emptied by clear");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !clear && short_found_reg |=> short_found_reg)
        else $error("short-history candidate lost during scan");

    a_take_sets: assert property (@(posedge clk) disable iff (!rst_n)
        !clear && valid && cand_full |=> full_found_reg)
        else $error("full-history candidate not recorded");

endmodule

FILE: design/lru_k_frame_replacer.sv
// LRU-K frame replacer top level: frame state, stamp memory and sequencer.
// Depends on lrukf_pkg and lrukf_victim_sel.
// Access, mark and remove items go from ST_IDLE to ST_EXEC, which sets the registered done.
// A victim item scans all NUM_FRAMES frames, one stamp read per cycle through one
// comparator, then ST_FINISH; ST_EVICT strobes done, or ST_EXEC with no evictable frame.
// One item at a time: busy stays high until the done cycle; start is taken again then.
// Reset clears all frame flags, counts and the stamp clock at once; no clearing pass.
module lru_k_frame_replacer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lrukf_pkg::KIND_W-1:0]         kind,
    input  logic [lrukf_pkg::FRAME_W-1:0]        frame,
    input  logic                                 mark_evictable,
    input  logic                                 cfg_we,
    input  logic [lrukf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrukf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                 done,
    output logic                                 victim_found,
    output logic [lrukf_pkg::FRAME_W-1:0]        victim_frame,
    output logic [lrukf_pkg::COUNT_W-1:0]        evictable_total
);
    import lrukf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_EVICT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;

    logic               present_reg [NUM_FRAMES];
    logic               present_next [NUM_FRAMES];
    logic               evict_reg [NUM_FRAMES];
    logic               evict_next [NUM_FRAMES];
    logic [FILL_W-1:0]  fill_reg [NUM_FRAMES];
    logic [FILL_W-1:0]  fill_next [NUM_FRAMES];
    logic [SLOT_W-1:0]  head_reg [NUM_FRAMES];
    logic [SLOT_W-1:0]  head_next [NUM_FRAMES];

    logic [COUNT_W-1:0] present_cnt_reg, present_cnt_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;

    kind_t              kind_reg, kind_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               mark_reg, mark_next;

    logic [FRAME_W-1:0] scan_reg, scan_next;
    logic               pv_reg, pv_next;
    logic [FRAME_W-1:0] pframe_reg, pframe_next;
    logic               pfull_reg, pfull_next;

    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [FRAME_W-1:0] vframe_reg, vframe_next;

    logic [STAMP_W-1:0] stamp_mem [NUM_FRAMES * MAX_K];
    logic [STAMP_W-1:0] rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [STAMP_W-1:0] mem_wdata;

    logic [FILL_W-1:0]  k_now;
    logic [FRAME_W-1:0] scan_frame;
    logic               scan_full;
    logic [SLOT_W-1:0]  scan_slot;
    logic               sel_clear;
    sel_result_t        sel;
    logic [FILL_W-1:0]  fill_base;
    logic [FRAME_W-1:0] evict_frame;

    always_comb
    begin
        if (depth_reg == '0)
            k_now = FILL_W'(1);
        else if (depth_reg > DEPTH_W'(MAX_K))
            k_now = FILL_W'(MAX_K);
        else
            k_now = FILL_W'(depth_reg);
    end

    assign scan_frame = scan_reg;
    assign scan_full  = fill_reg[scan_frame] >= k_now;
    assign scan_slot  = scan_full ? (head_reg[scan_frame] + SLOT_W'(k_now - FILL_W'(1)))
                                  : head_reg[scan_frame];
    assign mem_raddr  = {scan_frame, scan_slot};
    assign evict_frame = sel.short_found ? sel.short_frame : sel.full_frame;

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        depth_next       = depth_reg;
        present_next     = present_reg;
        evict_next       = evict_reg;
        fill_next        = fill_reg;
        head_next        = head_reg;
        present_cnt_next = present_cnt_reg;
        total_next       = total_reg;
        clock_next       = clock_reg;
        kind_next        = kind_reg;
        frame_next       = frame_reg;
        mark_next        = mark_reg;
        scan_next        = scan_reg;
        pv_next          = 1'b0;
        pframe_next      = scan_frame;
        pfull_next       = scan_full;
        done_next        = 1'b0;
        found_next       = 1'b0;
        vframe_next      = '0;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = clock_reg;
        sel_clear        = 1'b0;
        fill_base        = fill_reg[frame_reg];

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_LIMIT:   limit_next = cfg_wdata[LIMIT_W-1:0];
                CFG_HISTORY_DEPTH: depth_next = cfg_wdata[DEPTH_W-1:0];
                default:           limit_next = limit_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind_t'(kind);
                    frame_next = frame;
                    mark_next  = mark_evictable;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (kind_reg)
                    KIND_ACCESS:
                    begin
                        if ({1'b0, frame_reg} < limit_reg)
                        begin
                            if (!present_reg[frame_reg] &&
                                ({1'b0, present_cnt_reg} + 8'd1) > {1'b0, limit_reg})
                            begin
                                mem_we = 1'b0;
                            end
                            else
                            begin
                                if (!present_reg[frame_reg])
                                begin
                                    present_next[frame_reg] = 1'b1;
                                    present_cnt_next = present_cnt_reg + COUNT_W'(1);
                                    fill_base = '0;
                                end
                                if (clock_reg != '1)
                                    clock_next = clock_reg + STAMP_W'(1);
                                head_next[frame_reg] = head_reg[frame_reg] - SLOT_W'(1);
                                mem_we    = 1'b1;
                                mem_waddr = {frame_reg, head_next[frame_reg]};
                                mem_wdata = clock_next;
                                fill_next[frame_reg] = (fill_base < k_now)
                                    ? fill_base + FILL_W'(1) : fill_base;
                            end
                        end
                    end
                    KIND_MARK:
                    begin
                        if (present_reg[frame_reg] && evict_reg[frame_reg] != mark_reg)
                        begin
                            evict_next[frame_reg] = mark_reg;
                            if (mark_reg)
                                total_next = total_reg + COUNT_W'(1);
                            else if (total_reg != '0)
                                total_next = total_reg - COUNT_W'(1);
                        end
                    end
                    KIND_VICTIM:
                    begin
                        if (total_reg != '0)
                        begin
                            done_next  = 1'b0;
                            sel_clear  = 1'b1;
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (present_reg[frame_reg])
                        begin
                            if (evict_reg[frame_reg] && total_reg != '0)
                                total_next = total_reg - COUNT_W'(1);
                            present_next[frame_reg] = 1'b0;
                            evict_next[frame_reg]   = 1'b0;
                            fill_next[frame_reg]    = '0;
                            present_cnt_next = present_cnt_reg - COUNT_W'(1);
                        end
                    end
                    default: done_next = 1'b1;
                endcase
            end
            ST_SCAN:
            begin
                pv_next   = present_reg[scan_frame] && evict_reg[scan_frame];
                scan_next = scan_reg + FRAME_W'(1);
                if (scan_frame == FRAME_W'(NUM_FRAMES - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (sel.short_found || sel.full_found)
                begin
                    found_next  = 1'b1;
                    vframe_next = evict_frame;
                    if (evict_reg[evict_frame] && total_reg != '0)
                        total_next = total_reg - COUNT_W'(1);
                    present_next[evict_frame] = 1'b0;
                    evict_next[evict_frame]   = 1'b0;
                    fill_next[evict_frame]    = '0;
                    present_cnt_next = present_cnt_reg - COUNT_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    lrukf_victim_sel u_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (sel_clear),
        .valid      (pv_reg),
        .cand_frame (pframe_reg),
        .cand_full  (pfull_reg),
        .cand_key   (rdata_reg),
        .result     (sel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_W'(64);
            depth_reg       <= DEPTH_W'(2);
            present_cnt_reg <= '0;
            total_reg       <= '0;
            clock_reg       <= '0;
            pv_reg          <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                present_reg[i] <= 1'b0;
                evict_reg[i]   <= 1'b0;
                fill_reg[i]    <= '0;
                head_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            limit_reg       <= limit_next;
            depth_reg       <= depth_next;
            present_cnt_reg <= present_cnt_next;
            total_reg       <= total_next;
            clock_reg       <= clock_next;
            pv_reg          <= pv_next;
            done_reg        <= done_next;
            found_reg       <= found_next;
            present_reg     <= present_next;
            evict_reg       <= evict_next;
            fill_reg        <= fill_next;
            head_reg        <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        frame_reg  <= frame_next;
        mark_reg   <= mark_next;
        scan_reg   <= scan_next;
        pframe_reg <= pframe_next;
        pfull_reg  <= pfull_next;
        vframe_reg <= vframe_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stamp_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= stamp_mem[mem_raddr];
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign victim_found    = found_reg;
    assign victim_frame    = vframe_reg;
    assign evictable_total = total_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done strobed while busy");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> done_reg)
        else $error("victim reported outside a done cycle");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= present_cnt_reg)
        else $error("more evictable frames than present frames");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item taken without going busy");

endmodule

FILE: dv/lru_k_frame_replacer_tb.sv
// Self-checking testbench for lru_k_frame_replacer: directed table, then random phases
// over several frame limits, history depths and sender idle rates, checked by a predictor.
// Depends on lrukf_pkg and the lru_k_frame_replacer RTL.
`timescale 1ns / 1ps

module lru_k_frame_replacer_tb;

    import lrukf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 116;
    localparam int NUM_PHASES     = 8;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] vframe;
        logic [COUNT_W-1:0] total;
    } replacer_result_t;

    typedef struct {
        kind_t              kind;
        logic [FRAME_W-1:0] frame;
        logic               mark;
        bit                 typed;
        replacer_result_t   res;
    } stim_row_t;

    localparam replacer_result_t NO_RES = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    kind = '0;
    logic [FRAME_W-1:0]   frame = '0;
    logic                 mark_evictable = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                 done;
    logic                 victim_found;
    logic [FRAME_W-1:0]   victim_frame;
    logic [COUNT_W-1:0]   evictable_total;

    lru_k_frame_replacer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .frame           (frame),
        .mark_evictable  (mark_evictable),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .victim_found    (victim_found),
        .victim_frame    (victim_frame),
        .evictable_total (evictable_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    bit [NUM_FRAMES-1:0]   frame_present;
    bit [NUM_FRAMES-1:0]   frame_evict;
    bit [STAMP_W-1:0]      stamp_hist [NUM_FRAMES][MAX_K];
    int unsigned           hist_fill [NUM_FRAMES];
    bit [STAMP_W-1:0]      tick;
    bit [COUNT_W-1:0]      evict_count;
    bit [LIMIT_W-1:0]      cur_limit = 7'd64;
    bit [DEPTH_W-1:0]      cur_depth = 3'd2;

    replacer_result_t      pending_results [$];
    int                    mismatches = 0;
    int                    quiet_cycles = 0;

    stim_row_t directed_rows [25] = '{
        '{KIND_VICTIM,  6'd0,  1'b0, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_REMOVE,  6'd5,  1'b1, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_MARK,    6'd7,  1'b1, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_ACCESS,  6'd0,  1'b0, 1'b0, NO_RES},
        '{KIND_ACCESS,  6'd63, 1'b1, 1'b0, NO_RES},
        '{KIND_ACCESS,  6'd0,  1'b0, 1'b0, NO_RES},
        '{KIND_MARK,    6'd0,  1'b1, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{KIND_MARK,    6'd0,  1'b1, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{KIND_MARK,    6'd63, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{KIND_VICTIM,  6'd0,  1'b0, 1'b1, '{1'b1, 6'd63, 7'd1}},
        '{KIND_VICTIM,  6'd63, 1'b1, 1'b1, '{1'b1, 6'd0,  7'd0}},
        '{KIND_VICTIM,  6'd0,  1'b0, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_ACCESS,  6'd10, 1'b0, 1'b0, NO_RES},
        '{KIND_ACCESS,  6'd20, 1'b0, 1'b0, NO_RES},
        '{KIND_MARK,    6'd10, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{KIND_MARK,    6'd20, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{KIND_MARK,    6'd20, 1'b0, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{KIND_REMOVE,  6'd10, 1'b0, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_REMOVE,  6'd20, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd0}},
        '{KIND_ACCESS,  6'd33, 1'b0, 1'b0, NO_RES},
        '{KIND_ACCESS,  6'd33, 1'b0, 1'b0, NO_RES},
        '{KIND_ACCESS,  6'd31, 1'b0, 1'b0, NO_RES},
        '{KIND_MARK,    6'd33, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd1}},
        '{KIND_MARK,    6'd31, 1'b1, 1'b1, '{1'b0, 6'd0,  7'd2}},
        '{KIND_VICTIM,  6'd0,  1'b0, 1'b1, '{1'b1, 6'd31, 7'd1}}
    };

    bit [LIMIT_W-1:0] phase_limit [NUM_PHASES] = '{7'd64, 7'd1, 7'd8, 7'd127,
                                                   7'd16, 7'd0, 7'd64, 7'd4};
    bit [DEPTH_W-1:0] phase_depth [NUM_PHASES] = '{3'd1, 3'd4, 3'd3, 3'd7,
                                                   3'd0, 3'd5, 3'd4, 3'd2};
    int unsigned      phase_idle  [NUM_PHASES] = '{0, 80, 13, 0, 80, 13, 0, 80};

    function automatic int unsigned depth_in_use();
        int unsigned k;
        k = 32'(cur_depth);
        if (k == 0) k = 1;
        if (k > MAX_K) k = MAX_K;
        return k;
    endfunction

    function automatic void drop_frame(int unsigned f);
        if (frame_evict[f] && evict_count != 0) evict_count--;
        frame_present[f] = 1'b0;
        frame_evict[f]   = 1'b0;
        hist_fill[f]     = 0;
    endfunction

    function automatic void touch_frame(int unsigned f);
        int unsigned k;
        int unsigned n;
        k = depth_in_use();
        if (f >= cur_limit) return;
        if (!frame_present[f])
        begin
            n = $countones(frame_present);
            if (n + 1 > cur_limit) return;
            frame_present[f] = 1'b1;
            hist_fill[f]     = 0;
        end
        if (tick != '1) tick++;
        for (int i = MAX_K - 1; i > 0; i--)
            stamp_hist[f][i] = stamp_hist[f][i-1];
        stamp_hist[f][0] = tick;
        if (hist_fill[f] < k) hist_fill[f]++;
    endfunction

    function automatic bit choose_victim(output int unsigned pick);
        int unsigned      k;
        bit               hit;
        bit [STAMP_W-1:0] best_key;
        k        = depth_in_use();
        hit      = 1'b0;
        pick     = 0;
        best_key = '0;
        if (evict_count == 0) return 1'b0;
        for (int unsigned f = 0; f < NUM_FRAMES; f++)
        begin
            if (!frame_present[f] || !frame_evict[f] || hist_fill[f] >= k) continue;
            if (!hit || stamp_hist[f][0] < best_key)
            begin
                hit      = 1'b1;
                pick     = f;
                best_key = stamp_hist[f][0];
            end
        end
        if (!hit)
        begin
            for (int unsigned f = 0; f < NUM_FRAMES; f++)
            begin
                if (!frame_present[f] || !frame_evict[f] || hist_fill[f] < k) continue;
                if (!hit || stamp_hist[f][k-1] < best_key)
                begin
                    hit      = 1'b1;
                    pick     = f;
                    best_key = stamp_hist[f][k-1];
                end
            end
        end
        if (hit) drop_frame(pick);
        return hit;
    endfunction

    function automatic replacer_result_t predict_item(kind_t op, int unsigned f, bit mark);
        replacer_result_t r;
        int unsigned      pick;
        r = '0;
        case (op)
            KIND_ACCESS: touch_frame(f);
            KIND_MARK:
                if (frame_present[f] && frame_evict[f] != mark)
                begin
                    frame_evict[f] = mark;
                    if (mark) evict_count++;
                    else if (evict_count != 0) evict_count--;
                end
            KIND_VICTIM:
                if (choose_victim(pick))
                begin
                    r.found  = 1'b1;
                    r.vframe = pick[FRAME_W-1:0];
                end
            default:
                if (frame_present[f]) drop_frame(f);
        endcase
        r.total = evict_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // hold start across busy; keep it high when the next item follows at once
    task automatic send_item(int unsigned gap, kind_t op, int unsigned f, bit mark,
                             bit typed, replacer_result_t typed_res);
        replacer_result_t want;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= op;
        frame          <= f[FRAME_W-1:0];
        mark_evictable <= mark;
        do @(posedge clk); while (busy);
        want = predict_item(op, f, mark);
        pending_results.insert(pending_results.size(), typed ? typed_res : want);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(bit [LIMIT_W-1:0] limit, bit [DEPTH_W-1:0] depth);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_LIMIT;
        cfg_wdata <= CFG_DATA_W'(limit);
        @(posedge clk);
        cur_limit = limit;
        cfg_index <= CFG_HISTORY_DEPTH;
        cfg_wdata <= CFG_DATA_W'(depth);
        @(posedge clk);
        cur_depth = depth;
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned draw_gap(int unsigned pct);
        int unsigned g;
        g = 0;
        if (pct == 0) return 0;
        if ($urandom_range(7) == 0) return $urandom_range(80, 1);
        while (g < 60 && $urandom_range(99) < pct) g++;
        return g;
    endfunction

    task automatic send_random_item(int unsigned pct);
        int unsigned roll;
        int unsigned top;
        int unsigned f;
        kind_t       op;
        bit          mark;
        roll = $urandom_range(99);
        if (roll < 45)      op = KIND_ACCESS;
        else if (roll < 72) op = KIND_MARK;
        else if (roll < 88) op = KIND_VICTIM;
        else                op = KIND_REMOVE;
        top = (cur_limit == 0 || cur_limit > NUM_FRAMES) ? NUM_FRAMES - 1 : cur_limit - 1;
        if ($urandom_range(3) != 0) f = $urandom_range(top < 15 ? top : 15);
        else                        f = $urandom_range(NUM_FRAMES - 1);
        mark = (op == KIND_MARK) ? ($urandom_range(9) < 7) : 1'($urandom_range(1));
        send_item(draw_gap(pct), op, f, mark, 1'b0, NO_RES);
    endtask

    always @(posedge clk)
    begin
        replacer_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", victim_frame, 0);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (victim_found !== want.found)
                    report_mismatch("victim_found", victim_found, want.found);
                if (victim_frame !== want.vframe)
                    report_mismatch("victim_frame", victim_frame, want.vframe);
                if (evictable_total !== want.total)
                    report_mismatch("evictable_total", evictable_total, want.total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_item(0, directed_rows[i].kind, directed_rows[i].frame, directed_rows[i].mark,
                      directed_rows[i].typed, directed_rows[i].res);
        start <= 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_config(phase_limit[p], phase_depth[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item(phase_idle[p]);
            start <= 1'b0;
        end
        drain_results();
        repeat (NUM_FRAMES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
design/lrukf_pkg.sv
design/lrukf_victim_sel.sv
design/lru_k_frame_replacer.sv
dv/lru_k_frame_replacer_tb.sv
